// ===== design/rpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpf_pkg: shared types and constants for the rgb pixel filter
// Holds the filter mode codes, register indexes and the sepia arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rpf_pkg;

  localparam int unsigned PixW  = 24;
  localparam int unsigned ChW   = 8;
  localparam int unsigned NumCh = 3;
  localparam int unsigned CfgAddrW = 2;

  typedef enum logic [1:0] {
    MODE_INVERT = 2'd0,
    MODE_BLEND  = 2'd1,
    MODE_SEPIA  = 2'd2,
    MODE_MONO   = 2'd3
  } filter_mode_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_FILTER_MODE = 2'd0,
    REG_BLEND_COLOR = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_e;

  localparam logic [6:0] ThresholdReset = 7'd50;

  // sepia weighted sum fits in 19 bits: 255 * (393 + 769 + 189) = 344505
  localparam int unsigned SumW = 19;

  typedef logic [9:0] coef_t;
  typedef coef_t coef_row_t [NumCh];

  // coefficients in thousandths, row = output channel, column = input r, g, b
  localparam coef_row_t SepiaCoef [NumCh] = '{
    '{10'd393, 10'd769, 10'd189},
    '{10'd349, 10'd686, 10'd168},
    '{10'd272, 10'd534, 10'd131}
  };

  // floor(x / 1000) = (x * DivMul) >> DivShift, exact for x < 2^19
  localparam int unsigned DivShift = 29;
  localparam int unsigned DivMulW  = 20;
  localparam logic [DivMulW-1:0] DivMul = 20'd536871;
  localparam int unsigned ProdW = SumW + DivMulW;
  localparam int unsigned QuotW = ProdW - DivShift;

endpackage

`default_nettype wire

// ===== design/rgb_pixel_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_filter: per-pixel point filter on 0xRRGGBB words
// Invert, blend with a colour, sepia tone and monochrome threshold.
// ----------------------------------------------------------------------------
// a result passes the input, sum and divide registers in order before valid_o is raised
// throughput: one word per cycle, busy_o is never raised; the three register
//   stages (input, weighted sums, divide by 1000) each hold one word
// the receiver cannot stall, every result is shown for exactly one cycle
// reset clears the valid pipeline and loads the register reset values
`default_nettype none

module rgb_pixel_filter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [rpf_pkg::PixW-1:0]      pixel_in_i,
  output logic                               valid_o,
  output logic      [rpf_pkg::PixW-1:0]      pixel_out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rpf_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [rpf_pkg::PixW-1:0]      cfg_data_i
);

  localparam int unsigned ChW   = rpf_pkg::ChW;
  localparam int unsigned NumCh = rpf_pkg::NumCh;
  localparam int unsigned SumW  = rpf_pkg::SumW;
  localparam int unsigned ProdW = rpf_pkg::ProdW;
  localparam int unsigned QuotW = rpf_pkg::QuotW;

  // configuration registers
  rpf_pkg::filter_mode_e         mode_q;
  logic [rpf_pkg::PixW-1:0]      blend_q;
  logic [6:0]                    thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rpf_pkg::MODE_INVERT;
      blend_q <= '0;
      thr_q   <= rpf_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      case (rpf_pkg::cfg_reg_e'(cfg_addr_i))
        rpf_pkg::REG_FILTER_MODE: mode_q  <= rpf_pkg::filter_mode_e'(cfg_data_i[1:0]);
        rpf_pkg::REG_BLEND_COLOR: blend_q <= cfg_data_i;
        rpf_pkg::REG_THRESHOLD:   thr_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // valid pipeline
  logic in_vld_q, mid_vld_q, out_vld_q;
  logic accept;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      mid_vld_q <= in_vld_q;
      out_vld_q <= mid_vld_q;
    end
  end

  // input register
  logic [rpf_pkg::PixW-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pixel_in_i;
    end
  end

  // stage 1: sepia sums and the other filters
  logic [ChW-1:0]           ch_in  [NumCh];
  logic [ChW-1:0]           ch_bl  [NumCh];
  logic [SumW-1:0]          sum_d  [NumCh];
  logic [SumW-1:0]          sum_q  [NumCh];
  logic [rpf_pkg::PixW-1:0] plain_d, plain_q;
  logic                     sepia_d, sepia_q;
  logic [ChW-1:0]           max_rg, max_rgb;
  logic [14:0]              max_scaled, thr_scaled;

  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      ch_in[k] = pix_q[(NumCh-1-k)*ChW +: ChW];
      ch_bl[k] = blend_q[(NumCh-1-k)*ChW +: ChW];
    end
    for (int o = 0; o < NumCh; o++) begin
      sum_d[o] = SumW'(rpf_pkg::SepiaCoef[o][0]) * SumW'(ch_in[0])
               + SumW'(rpf_pkg::SepiaCoef[o][1]) * SumW'(ch_in[1])
               + SumW'(rpf_pkg::SepiaCoef[o][2]) * SumW'(ch_in[2]);
    end
    max_rg     = (ch_in[1] > ch_in[0]) ? ch_in[1] : ch_in[0];
    max_rgb    = (ch_in[2] > max_rg) ? ch_in[2] : max_rg;
    max_scaled = 15'(max_rgb) * 15'd100;
    thr_scaled = 15'(thr_q) * 15'd255;
    sepia_d    = 1'b0;
    plain_d    = '0;
    case (mode_q)
      rpf_pkg::MODE_INVERT: begin
        plain_d = ~pix_q;
      end
      rpf_pkg::MODE_BLEND: begin
        for (int k = 0; k < NumCh; k++) begin
          plain_d[(NumCh-1-k)*ChW +: ChW] =
            ChW'(({1'b0, ch_in[k]} + {1'b0, ch_bl[k]}) >> 1);
        end
      end
      rpf_pkg::MODE_SEPIA: begin
        sepia_d = 1'b1;
      end
      rpf_pkg::MODE_MONO: begin
        plain_d = (max_scaled > thr_scaled) ? '1 : '0;
      end
      default: begin
        plain_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      sum_q   <= sum_d;
      plain_q <= plain_d;
      sepia_q <= sepia_d;
    end
  end

  // stage 2: divide by 1000 through the reciprocal, saturate, select
  logic [ProdW-1:0]         prod   [NumCh];
  logic [QuotW-1:0]         quot   [NumCh];
  logic [rpf_pkg::PixW-1:0] sepia_px;
  logic [rpf_pkg::PixW-1:0] out_d, out_q;

  always_comb begin
    for (int o = 0; o < NumCh; o++) begin
      prod[o] = ProdW'(sum_q[o]) * ProdW'(rpf_pkg::DivMul);
      quot[o] = prod[o][ProdW-1:rpf_pkg::DivShift];
      sepia_px[(NumCh-1-o)*ChW +: ChW] =
        (quot[o] > QuotW'(255)) ? '1 : quot[o][ChW-1:0];
    end
    out_d = sepia_q ? sepia_px : plain_q;
  end

  always_ff @(posedge clk_i) begin
    if (mid_vld_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o     = out_vld_q;
  assign pixel_out_o = out_q;

endmodule

`default_nettype wire
